// File: design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 64;
    localparam int ROUNDS  = 64;
    localparam int WIN_W   = 512;

    localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0]        LEN_START = 6'd56;
    localparam logic [5:0]        BLK_LAST  = 6'd63;
    localparam logic [5:0]        RND_LAST  = 6'd63;
    localparam logic [2:0]        WORD_LAST = 3'd7;

    // Initial hash value; index 0 is H0
    localparam logic [7:0][WORD_W-1:0] SHA_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Source of the byte pushed into the block window
    typedef enum logic [1:0] {
        PUSH_MSG  = 2'd0,
        PUSH_PAD  = 2'd1,
        PUSH_ZERO = 2'd2,
        PUSH_LEN  = 2'd3
    } t_push_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic        push;
        t_push_sel   push_sel;
        logic        count_len;
        logic [2:0]  len_sel;
        logic        load_work;
        logic        round_en;
        logic [5:0]  round_idx;
        logic        update_hash;
        logic        restart;
        logic [2:0]  out_idx;
    } t_cmd;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] v);
        return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] v);
        return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sig0(input logic [WORD_W-1:0] v);
        return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sig1(input logic [WORD_W-1:0] v);
        return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

    // Round constants
    function automatic logic [WORD_W-1:0] round_k(input logic [5:0] t);
        logic [WORD_W-1:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

endpackage

// File: design/sha_if.sv
// ----------------------------------------------------------------------------
// sha_if
// Valid/ready channels: message bytes in, digest words out.
// ----------------------------------------------------------------------------
interface sha_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_valid, end_of_message,
                    input ready);
    modport sink   (input valid, data_byte, byte_valid, end_of_message,
                    output ready);
endinterface

interface sha_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word,
                    input ready);
    modport sink   (input valid, digest_word, word_index, last_word,
                    output ready);
endinterface

// File: design/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, round count and digest read-out.
// ----------------------------------------------------------------------------
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_byte_valid,
    input  logic       i_end_of_message,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_ROUND  = 8'b0000_0100,
        S_UPDATE = 8'b0000_1000,
        S_PAD    = 8'b0001_0000,
        S_ZERO   = 8'b0010_0000,
        S_LEN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    t_state     r_ret,   n_ret;    // where to go once the block is folded in
    logic [5:0] r_fill,  n_fill;
    logic [5:0] r_round, n_round;
    logic [2:0] r_widx,  n_widx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= '0;
            r_round <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_widx  <= n_widx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fill  = r_fill;
        n_round = r_round;
        n_widx  = r_widx;

        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        o_cmd             = '0;
        o_cmd.push_sel    = PUSH_MSG;
        o_cmd.len_sel     = r_fill[2:0];
        o_cmd.round_idx   = r_round;
        o_cmd.out_idx     = r_widx;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_byte_valid) begin
                        o_cmd.push      = 1'b1;
                        o_cmd.count_len = 1'b1;
                        n_fill          = r_fill + 6'd1;
                    end
                    if (i_byte_valid && r_fill == BLK_LAST) begin
                        n_ret   = i_end_of_message ? S_PAD : S_IDLE;
                        n_state = S_LOAD;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_PAD;
                n_fill         = r_fill + 6'd1;
                if (r_fill == BLK_LAST) begin
                    n_ret   = S_ZERO;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (r_fill == LEN_START) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_sel = PUSH_ZERO;
                    n_fill         = r_fill + 6'd1;
                    if (r_fill == BLK_LAST) begin
                        n_ret   = S_ZERO;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LEN: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_LEN;
                n_fill         = r_fill + 6'd1;
                if (r_fill == BLK_LAST) begin
                    n_ret   = S_OUT;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_round         = '0;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round        = r_round + 6'd1;
                if (r_round == RND_LAST) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update_hash = 1'b1;
                n_state           = r_ret;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == WORD_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Datapath: 512-bit block window, bit length, working variables, hash state.
// ----------------------------------------------------------------------------
module sha_dp
    import sha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic [WORD_W-1:0] o_digest_word
);

    // Oldest word sits at the top; bytes and schedule words enter at the bottom
    logic [WIN_W-1:0]           r_win;
    logic [LEN_W-1:0]           r_len;
    logic [7:0][WORD_W-1:0]     r_hash;
    logic [WORD_W-1:0]          r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;

    logic [BYTE_W-1:0] push_byte;
    logic [WORD_W-1:0] w0, w1, w9, w14, w_next;
    logic [WORD_W-1:0] t1, t2;

    assign w0  = r_win[511:480];
    assign w1  = r_win[479:448];
    assign w9  = r_win[223:192];
    assign w14 = r_win[63:32];

    // Window holds w[t..t+15]; this is w[t+16]
    assign w_next = small_sig1(w14) + w9 + small_sig0(w1) + w0;

    assign t1 = r_h + big_sig1(r_e) + ((r_e & r_f) ^ (~r_e & r_g))
              + round_k(i_cmd.round_idx) + w0;
    assign t2 = big_sig0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    always_comb begin
        case (i_cmd.push_sel)
            PUSH_MSG:  push_byte = i_data_byte;
            PUSH_PAD:  push_byte = PAD_BYTE;
            PUSH_ZERO: push_byte = '0;
            PUSH_LEN:  push_byte = r_len[{~i_cmd.len_sel, 3'b000} +: BYTE_W];
            default:   push_byte = '0;
        endcase
    end

    assign o_digest_word = r_hash[i_cmd.out_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_win <= {r_win[WIN_W-BYTE_W-1:0], push_byte};
        end else if (i_cmd.round_en) begin
            r_win <= {r_win[WIN_W-WORD_W-1:0], w_next};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            r_a <= r_hash[0]; r_b <= r_hash[1]; r_c <= r_hash[2]; r_d <= r_hash[3];
            r_e <= r_hash[4]; r_f <= r_hash[5]; r_g <= r_hash[6]; r_h <= r_hash[7];
        end else if (i_cmd.round_en) begin
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_len  <= '0;
            r_hash <= SHA_IV;
        end else begin
            if (i_cmd.count_len) begin
                r_len <= r_len + LEN_W'(BYTE_W);
            end
            if (i_cmd.update_hash) begin
                r_hash[0] <= r_hash[0] + r_a;
                r_hash[1] <= r_hash[1] + r_b;
                r_hash[2] <= r_hash[2] + r_c;
                r_hash[3] <= r_hash[3] + r_d;
                r_hash[4] <= r_hash[4] + r_e;
                r_hash[5] <= r_hash[5] + r_f;
                r_hash[6] <= r_hash[6] + r_g;
                r_hash[7] <= r_hash[7] + r_h;
            end
        end
    end

endmodule

// File: design/sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// SHA-256 over a byte stream: one byte per beat in, eight digest words out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                 | beat
//  ---------+-----+-----------------------------------------+-----------------
//  i_byte   | in  | data_byte, byte_valid, end_of_message   | one byte/marker
//  o_word   | out | digest_word, word_index, last_word      | one digest word
//
//  Byte beat: the 64th byte of a block starts a compression (load,
//  64 rounds, hash update) in the one round unit.
//  End mark: pad, zero and length bytes are pushed into the window,
//  then one or two compressions and eight output beats.
//  i_byte stalls through compression, padding and read-out; o_word may stall
//  and the word holds. Sync active-low reset: initial hash, zero bit length.
//
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core
    import sha_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    sha_byte_if.sink         i_byte,
    sha_word_if.source       o_word
);

    t_cmd cmd;
    logic out_valid;
    logic in_ready;

    // Sequencer: owns fill count, round count and word index
    sha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_byte.valid),
        .i_byte_valid     (i_byte.byte_valid),
        .i_end_of_message (i_byte.end_of_message),
        .o_in_ready       (in_ready),
        .o_out_valid      (out_valid),
        .i_out_ready      (o_word.ready),
        .o_cmd            (cmd)
    );

    // Block window, schedule, round logic and hash state
    sha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_byte.data_byte),
        .o_digest_word (o_word.digest_word)
    );

    assign i_byte.ready      = in_ready;
    assign o_word.valid      = out_valid;
    assign o_word.word_index = cmd.out_idx;
    assign o_word.last_word  = (cmd.out_idx == WORD_LAST);

endmodule

// File: bench/sha256_byte_stream_hasher_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core_checker
// Watches both channels of the hasher, keeps its own SHA-256 chaining state
// and checks every digest word against the value it works out.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    input  logic        i_in_byte_valid,
    input  logic        i_in_eom,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_word,
    input  logic [2:0]  i_out_index,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int         BLOCK_BYTES  = 64;
    localparam int         LEN_FIELD_AT = 56;
    localparam logic [7:0] PAD_MARK     = 8'h80;

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] K_TAB = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_beat;

    logic [7:0]   msg_block [BLOCK_BYTES];
    int           fill_bytes;
    logic [63:0]  bit_count;
    logic [31:0]  chain [8];
    t_digest_beat expected_digest_q [$];
    int           fail_total;
    int           pending_words;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_words;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of msg_block into the chaining words
    function automatic void compress_into_chain();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function automatic void start_message();
        fill_bytes = 0;
        bit_count  = '0;
        for (int i = 0; i < 8; i++) chain[i] = IV_WORDS[i];
    endfunction

    // Pad, append the length, finish the hash and queue its eight words
    function automatic void close_message();
        int           idx;
        t_digest_beat beat;
        idx = fill_bytes;
        msg_block[idx] = PAD_MARK;
        idx++;
        if (idx > LEN_FIELD_AT) begin
            while (idx < BLOCK_BYTES) begin
                msg_block[idx] = 8'h00;
                idx++;
            end
            compress_into_chain();
            idx = 0;
        end
        while (idx < LEN_FIELD_AT) begin
            msg_block[idx] = 8'h00;
            idx++;
        end
        for (int i = 0; i < 8; i++) msg_block[LEN_FIELD_AT+i] = bit_count[63-8*i -: 8];
        compress_into_chain();
        for (int i = 0; i < 8; i++) begin
            beat.digest_word = chain[i];
            beat.word_index  = 3'(i);
            beat.last_word   = (i == 7);
            expected_digest_q.push_back(beat);
            pending_words++;
        end
        start_message();
    endfunction

    function automatic void absorb_beat(input logic [7:0] data, input logic bv, input logic eom);
        if (bv) begin
            msg_block[fill_bytes] = data;
            fill_bytes++;
            bit_count += 64'd8;
            if (fill_bytes == BLOCK_BYTES) begin
                compress_into_chain();
                fill_bytes = 0;
            end
        end
        if (eom) close_message();
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_total++;
        $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    initial begin
        fail_total    = 0;
        pending_words = 0;
        start_message();
    end

    always @(posedge i_clk) begin
        t_digest_beat want;
        if (!i_rst_n) begin
            start_message();
            expected_digest_q.delete();
            pending_words = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_digest_q.size() == 0) begin
                    flag_mismatch("digest word with none expected", i_out_word, 32'h0);
                end else begin
                    want = expected_digest_q.pop_front();
                    pending_words--;
                    if (i_out_word !== want.digest_word)
                        flag_mismatch("digest_word", i_out_word, want.digest_word);
                    if (i_out_index !== want.word_index)
                        flag_mismatch("word_index", 32'(i_out_index), 32'(want.word_index));
                    if (i_out_last !== want.last_word)
                        flag_mismatch("last_word", 32'(i_out_last), 32'(want.last_word));
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_beat(i_in_data, i_in_byte_valid, i_in_eom);
        end
    end

endmodule

// File: bench/sha256_byte_stream_hasher_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core_tb
// Feeds byte messages of varied lengths through the hasher under bursty input
// and a stalling output, and lets the checker verify every digest word.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core_tb;

    localparam int  RANDOM_ITEMS = 270;
    localparam int  DRAIN_CYCLES = 200;   // two compressions plus slack
    localparam real RUN_LIMIT_NS = 2_000_000.0;

    // Output-side stall behaviour, re-picked every so often
    typedef enum logic [1:0] {
        RX_FREE,     // always ready
        RX_CHOPPY,   // ready about half the time
        RX_SPARSE    // mostly stalled, long holds on a word
    } t_rx_mode;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic     rx_ready  = 1'b0;
    t_rx_mode rx_mode   = RX_FREE;
    int       rx_left   = 0;

    int burst_left   = 0;
    int items_sent   = 0;   // bytes and end marks only
    int bytes_sent   = 0;
    int messages     = 0;
    int idle_beats   = 0;
    int fail_count;
    int pending;

    sha_byte_if byte_ch ();
    sha_word_if word_ch ();

    assign word_ch.ready = rx_ready;

    sha256_byte_stream_hasher_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .o_word  (word_ch)
    );

    sha256_byte_stream_hasher_core_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (byte_ch.valid),
        .i_in_ready      (byte_ch.ready),
        .i_in_data       (byte_ch.data_byte),
        .i_in_byte_valid (byte_ch.byte_valid),
        .i_in_eom        (byte_ch.end_of_message),
        .i_out_valid     (word_ch.valid),
        .i_out_ready     (word_ch.ready),
        .i_out_word      (word_ch.digest_word),
        .i_out_index     (word_ch.word_index),
        .i_out_last      (word_ch.last_word),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: ready pattern re-picks its character when its hold count runs out, so
    // stalls land on every digest word position, with free-running stretches
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:   rx_ready <= 1'b1;
            RX_CHOPPY: rx_ready <= 1'($urandom_range(0, 1));
            default:   rx_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // One beat on the byte channel, held until taken. After the handshake
    // the sender may end its burst and sit idle; valid is only lowered
    // here, so it is never dropped and raised in one step.
    task automatic send_beat(input logic [7:0] data, input logic bv, input logic eom);
        int gap_len;
        byte_ch.valid          <= 1'b1;
        byte_ch.data_byte      <= data;
        byte_ch.byte_valid     <= bv;
        byte_ch.end_of_message <= eom;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        if (bv) bytes_sent++;
        if (eom) messages++;
        if (bv || eom) items_sent++;
        else idle_beats++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0) begin
                byte_ch.valid     <= 1'b0;
                byte_ch.data_byte <= 8'($urandom_range(0, 255));
                repeat (gap_len) @(posedge clk);
            end
        end
    endtask

    // A whole message of random bytes, sprinkled with ignored beats. The
    // end mark rides on the last byte or follows as a beat of its own.
    task automatic send_message(input int len);
        logic       mark_on_byte;
        logic [7:0] data;
        mark_on_byte = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            case ($urandom_range(0, 9))
                0:       data = 8'h00;
                1:       data = 8'hff;
                default: data = 8'($urandom_range(0, 255));
            endcase
            send_beat(data, 1'b1, mark_on_byte && (k == len - 1));
        end
        if (len == 0 || !mark_on_byte)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        byte_ch.valid          <= 1'b0;
        byte_ch.data_byte      <= 8'h00;
        byte_ch.byte_valid     <= 1'b0;
        byte_ch.end_of_message <= 1'b0;
        rst_n                  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, with an all-ones byte that must be ignored
        send_beat(8'hff, 1'b0, 1'b1);
        // "abc", end mark on the last byte
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        // byte extremes around an ignored beat, closed by a bare end mark
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b1);
        // one byte equal to the pad marker
        send_beat(8'h80, 1'b1, 1'b1);

        // Block boundaries first: last length with a one-block tail, the
        // first that spills padding into a second block, and a full block
        send_message(55);
        send_message(56);
        send_message(64);

        // Random message lengths, mostly short, some around the boundaries
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: len = $urandom_range(0, 12);
                4:          len = $urandom_range(0, 2);
                5, 6:       len = $urandom_range(52, 70);
                default:    len = $urandom_range(13, 40);
            endcase
            send_message(len);
        end
        byte_ch.valid <= 1'b0;

        // Let the checker see the last beat before asking what is left
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages: %0d bytes, %0d ignored beats, %0d digest words",
                 messages, bytes_sent, idle_beats, messages * 8);
        $display("Covered empty, block-full and two-block-padding messages under stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            if (pending != 0) $display("%0d digest words never arrived", pending);
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d digest words outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule
